[sv/ssr_pkg.sv]
// Package for the streaming substring replace block.
// Shared widths, register indexes and the job record passed from front to back.
package ssr_pkg;

    localparam int BYTE_W   = 8;
    localparam int SLOTS    = 8;
    localparam int WORD_W   = BYTE_W * SLOTS;
    localparam int LEN_W    = 4;
    localparam int IDX_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [LEN_W-1:0]  n;
        logic              last;
    } t_job;

endpackage

[sv/ssr_in_if.sv]
// Input channel of the substring replace block: one source byte per transaction.
// Standalone; no package dependency.
interface ssr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

[sv/ssr_out_if.sv]
// Output channel of the substring replace block: one result byte per transaction.
// Standalone; no package dependency.
interface ssr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_output;

    modport source (output valid, output out_byte, output byte_valid, output end_of_output,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input end_of_output,
                    output ready);
endinterface

[sv/ssr_front.sv]
// Front end: configuration registers, pending window, pattern compare, job build.
// Depends on ssr_pkg.
module ssr_front
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_byte,
    input  logic                 i_last,
    output logic                 o_push,
    output t_job                 o_job
);

    localparam int WIN  = (MAX_PATTERN < SLOTS) ? MAX_PATTERN : SLOTS;
    localparam int RLIM = (MAX_REPLACEMENT < SLOTS) ? MAX_REPLACEMENT : SLOTS;
    localparam int CW   = $clog2(WIN + 1);
    localparam logic [LEN_W-1:0] PLIM = LEN_W'(WIN);
    localparam logic [LEN_W-1:0] RLEN_LIM = LEN_W'(RLIM);

    logic [WORD_W-1:0] r_pat, n_pat;
    logic [LEN_W-1:0]  r_plen_raw, n_plen_raw;
    logic [WORD_W-1:0] r_rep, n_rep;
    logic [LEN_W-1:0]  r_rlen_raw, n_rlen_raw;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_win [WIN];
    logic [BYTE_W-1:0] n_win [WIN];

    logic [LEN_W-1:0]  plen, rlen, cnt_eff, cnt1;
    logic [BYTE_W-1:0] w_new [WIN];
    logic [WORD_W-1:0] flush;
    logic              full, match;

    always_comb begin
        plen = (r_plen_raw > PLIM) ? PLIM : r_plen_raw;
        rlen = (r_rlen_raw > RLEN_LIM) ? RLEN_LIM : r_rlen_raw;
        cnt_eff = (LEN_W'(r_cnt) >= plen) ? '0 : LEN_W'(r_cnt);
        cnt1 = cnt_eff + LEN_W'(1);
        full = (plen != '0) && (cnt1 == plen);
        flush = '0;
        match = 1'b1;
        for (int i = 0; i < WIN; i++) begin
            w_new[i] = (cnt_eff == LEN_W'(i)) ? i_byte : r_win[i];
            flush[BYTE_W*i +: BYTE_W] = w_new[i];
            if ((LEN_W'(i) < plen) && (w_new[i] != r_pat[BYTE_W*i +: BYTE_W])) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        o_job.last = i_last;
        if (plen == '0) begin
            o_job.data = {{(WORD_W-BYTE_W){1'b0}}, i_byte};
            o_job.n    = LEN_W'(1);
        end else if (full && match) begin
            o_job.data = r_rep;
            o_job.n    = rlen;
        end else if (full) begin
            o_job.data = flush;
            o_job.n    = i_last ? plen : LEN_W'(1);
        end else begin
            o_job.data = flush;
            o_job.n    = i_last ? cnt1 : '0;
        end
        o_push = i_accept && ((o_job.n != '0) || i_last);
    end

    always_comb begin
        n_pat      = r_pat;
        n_plen_raw = r_plen_raw;
        n_rep      = r_rep;
        n_rlen_raw = r_rlen_raw;
        n_cnt      = r_cnt;
        n_win      = r_win;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES: begin
                    n_pat = i_cfg_data;
                end
                CFG_PATTERN_LENGTH: begin
                    n_plen_raw = i_cfg_data[LEN_W-1:0];
                    n_cnt      = '0;
                end
                CFG_REPLACEMENT_BYTES: begin
                    n_rep = i_cfg_data;
                end
                CFG_REPLACEMENT_LENGTH: begin
                    n_rlen_raw = i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (i_last || (plen == '0) || (full && match)) begin
                n_cnt = '0;
            end else if (full) begin
                n_cnt = CW'(plen - LEN_W'(1));
            end else begin
                n_cnt = CW'(cnt1);
            end
            if (full && !match) begin
                for (int i = 0; i < WIN - 1; i++) begin
                    n_win[i] = w_new[i+1];
                end
                n_win[WIN-1] = w_new[WIN-1];
            end else begin
                n_win = w_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_plen_raw <= '0;
            r_rep      <= '0;
            r_rlen_raw <= '0;
            r_cnt      <= '0;
        end else begin
            r_pat      <= n_pat;
            r_plen_raw <= n_plen_raw;
            r_rep      <= n_rep;
            r_rlen_raw <= n_rlen_raw;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

[sv/ssr_queue.sv]
// Job queue between front and back end, register based, first in first out.
// Depends on ssr_pkg.
module ssr_queue
    import ssr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_nonempty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[sv/ssr_back.sv]
// Back end: expands queued jobs into result bytes through an output register.
// Depends on ssr_pkg and ssr_out_if.
module ssr_back
    import ssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_nonempty,
    output logic        o_pop,
    ssr_out_if.source   o_out
);

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_bv, n_bv;
    logic              r_eoo, n_eoo;
    logic              can_load, load, item_final;

    always_comb begin
        can_load   = !r_valid || o_out.ready;
        load       = can_load && i_nonempty;
        item_final = ({1'b0, r_idx} + LEN_W'(1)) >= i_head.n;
        o_pop      = load && item_final;

        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_bv    = r_bv;
        n_eoo   = r_eoo;
        if (load) begin
            n_idx   = item_final ? '0 : r_idx + IDX_W'(1);
            n_valid = 1'b1;
            n_bv    = (i_head.n != '0);
            n_byte  = n_bv ? i_head.data[{r_idx, 3'b000} +: BYTE_W] : '0;
            n_eoo   = i_head.last && item_final;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bv   <= n_bv;
        r_eoo  <= n_eoo;
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_byte;
    assign o_out.byte_valid    = r_bv;
    assign o_out.end_of_output = r_eoo;

endmodule

[sv/stream_substring_replace.sv]
// Streaming substring replace, top level: front end, job queue, back end.
// Depends on ssr_pkg, ssr_in_if, ssr_out_if, ssr_front, ssr_queue, ssr_back.
//
//   channel   dir  handshake      payload
//   i_in      in   valid/ready    in_byte[7:0], end_of_input
//   o_out     out  valid/ready    out_byte[7:0], byte_valid, end_of_output
//   cfg       in   i_cfg_we       i_cfg_index[1:0], i_cfg_data[63:0]
//
// Input takes one byte per cycle while the 4-entry job queue has room.
// Output gives one result per cycle while ready and a job is queued; a match
// yields one result per replacement byte, the end of a string one per flushed byte
// (at most 8). A result passes through the job queue, then the output register.
// Reset is synchronous, active low; no clearing pass follows it.
module stream_substring_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    ssr_in_if.sink               i_in,
    ssr_out_if.source            o_out
);

    logic accept, push, full, pop, nonempty;
    t_job job, head;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    ssr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_in.in_byte),
        .i_last      (i_in.end_of_input),
        .o_push      (push),
        .o_job       (job)
    );

    ssr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty)
    );

    ssr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_nonempty (nonempty),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule
